// File: rtl/slr_pkg.sv
// slr_pkg: shared types and constants of the stereo linear resampler.
// Sample pair, front-to-back command and result item layouts.
// No dependencies.
package slr_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STEP_CFG_W = 17;

  // Input rate 32822.75390625 Hz over a 48 kHz output, in Q16.
  localparam logic [STEP_CFG_W-1:0] STEP_RESET = 17'd44814;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef enum logic {
    MODE_INTERP = 1'b0,
    MODE_TAIL   = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e  mode;     // first run of the command
    logic   tail_en;  // held outputs follow the blended ones
    pair_t  prev;
    pair_t  cur;
  } cmd_t;

  typedef struct packed {
    pair_t  pair;
    logic   last;
  } res_t;

endpackage

// File: rtl/slr_fifo.sv
// slr_fifo: small first-in first-out queue of flops with level count.
// Used between front and back and on the result side.
// No dependencies.
module slr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           pop_i,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [WIDTH-1:0]               rdata_o,
  output logic [$clog2(DEPTH + 1)-1:0]   count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/slr_front.sv
// slr_front: accepts input items, tracks phase and block state, and
// turns each item into at most one command for the back end.
// Depends on slr_pkg.
module slr_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [slr_pkg::STEP_CFG_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  input  logic                            cmd_full_i,
  input  slr_pkg::pair_t                  sample_i,
  input  logic                            block_start_i,
  input  logic                            block_end_i,
  output logic                            cmd_push_o,
  output slr_pkg::cmd_t                   cmd_o,
  output logic [FRAC_BITS:0]              cmd_phase_o,
  output logic [FRAC_BITS:0]              cmd_step_o
);

  import slr_pkg::*;

  localparam int unsigned PW = FRAC_BITS + 1;   // phase stays below 2.0
  localparam int unsigned SW = FRAC_BITS + 4;   // phase plus four steps
  localparam int unsigned EW = (STEP_CFG_W > PW) ? STEP_CFG_W : PW;
  localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] STEP_MIN = PW'(1) << (FRAC_BITS - 2);
  localparam logic [PW-1:0] STEP_MAX = '1;

  logic [STEP_CFG_W-1:0] step_cfg_q;
  pair_t                 prev_q;
  logic [PW-1:0]         phase_q, phase_d;
  logic                  have_prev_q, have_prev_d;

  logic                  accept;
  logic [EW-1:0]         cfg_ext;
  logic [PW-1:0]         step_c;
  logic [SW-1:0]         sum [4];
  logic [SW-1:0]         hit;
  logic                  fresh, interp, tail;
  logic [PW-1:0]         phase_new;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i & ~cmd_full_i;

  always_comb begin
    cfg_ext = EW'(step_cfg_q);
    if (cfg_ext < EW'(STEP_MIN)) begin
      step_c = STEP_MIN;
    end else if (cfg_ext > EW'(STEP_MAX)) begin
      step_c = STEP_MAX;
    end else begin
      step_c = cfg_ext[PW-1:0];
    end
  end

  // Position after one to four outputs; the first that reaches 1.0 ends
  // the blended run. Four steps always get there from below 1.0.
  always_comb begin
    sum[0] = SW'(phase_q) + SW'(step_c);
    sum[1] = SW'(phase_q) + (SW'(step_c) << 1);
    sum[2] = sum[1] + SW'(step_c);
    sum[3] = SW'(phase_q) + (SW'(step_c) << 2);
    hit    = sum[3];
    for (int k = 2; k >= 0; k--) begin
      if (sum[k] >= SW'(ONE)) begin
        hit = sum[k];
      end
    end
  end

  always_comb begin
    fresh  = block_start_i | ~have_prev_q;
    interp = ~fresh & (phase_q < ONE);
    if (fresh) begin
      phase_new = '0;
    end else if (interp) begin
      phase_new = PW'(hit - SW'(ONE));
    end else begin
      phase_new = phase_q - ONE;
    end
    tail = block_end_i & (phase_new < ONE);
  end

  always_comb begin
    cmd_push_o    = accept & (interp | tail);
    cmd_o.mode    = interp ? MODE_INTERP : MODE_TAIL;
    cmd_o.tail_en = tail;
    cmd_o.prev    = prev_q;
    cmd_o.cur     = sample_i;
    cmd_phase_o   = interp ? phase_q : phase_new;
    cmd_step_o    = step_c;
  end

  always_comb begin
    phase_d     = phase_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      phase_d     = block_end_i ? '0 : phase_new;
      have_prev_d = ~block_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cfg_q  <= STEP_RESET;
      prev_q      <= '0;
      phase_q     <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_cfg_q <= cfg_data_i;
      end
      if (accept) begin
        prev_q <= sample_i;
      end
      phase_q     <= phase_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

// File: rtl/slr_back.sv
// slr_back: runs commands from the front, one result per cycle while loaded and the
// result queue has room: phase step, blend multiply, then truncating scale into it.
// Depends on slr_pkg.
module slr_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_empty_i,
  output logic                               cmd_pop_o,
  input  slr_pkg::cmd_t                      cmd_i,
  input  logic [FRAC_BITS:0]                 cmd_phase_i,
  input  logic [FRAC_BITS:0]                 cmd_step_i,
  input  logic [$clog2(OUT_DEPTH + 1)-1:0]   res_count_i,
  output logic                               res_push_o,
  output slr_pkg::res_t                      res_o
);

  import slr_pkg::*;

  localparam int unsigned PW  = FRAC_BITS + 1;
  localparam int unsigned NW  = FRAC_BITS + 2;
  localparam int unsigned PRW = FRAC_BITS + SAMPLE_W + 2;
  localparam int unsigned CW  = $clog2(OUT_DEPTH + 1);
  localparam logic [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;

  logic                      active_q;
  mode_e                     mode_q;
  logic                      tail_en_q;
  logic [PW-1:0]             ph_q;
  logic [PW-1:0]             step_q;
  pair_t                     prev_q, cur_q;

  logic                      p1_valid_q;
  logic                      p1_tail_q;
  logic                      p1_last_q;
  pair_t                     p1_prev_q, p1_cur_q;
  logic signed [PRW-1:0]     p1_prod_l_q, p1_prod_r_q;

  logic                      room, issue, load, reach, done;
  logic [NW-1:0]             ph_next;
  logic [PW-1:0]             ph_wrap;
  logic signed [FRAC_BITS:0] f_s;
  logic signed [SAMPLE_W:0]  diff_l, diff_r;
  logic signed [PRW-1:0]     prod_l, prod_r;
  logic signed [PRW-1:0]     num_l, num_r;

  // Quotient by 2^FRAC_BITS, rounded toward zero.
  function automatic sample_t scale_down(input logic signed [PRW-1:0] num);
    logic signed [PRW-1:0] q;
    q = num >>> FRAC_BITS;
    if (num[PRW-1] && (num[FRAC_BITS-1:0] != '0)) begin
      q = q + PRW'(1);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // Leave a slot for the item still in the scale stage.
  assign room  = ({1'b0, res_count_i} + (CW + 1)'(p1_valid_q)) < (CW + 1)'(OUT_DEPTH);
  assign issue = active_q & room;
  assign load  = ~active_q & ~cmd_empty_i;
  assign cmd_pop_o = load;

  assign ph_next = NW'(ph_q) + NW'(step_q);
  assign reach   = (ph_next >= ONE_N);
  assign ph_wrap = PW'(ph_next - ONE_N);
  assign done    = reach & ((mode_q == MODE_TAIL) | ~tail_en_q);

  assign f_s    = $signed({1'b0, ph_q[FRAC_BITS-1:0]});
  assign diff_l = (SAMPLE_W + 1)'(cur_q.left) - (SAMPLE_W + 1)'(prev_q.left);
  assign diff_r = (SAMPLE_W + 1)'(cur_q.right) - (SAMPLE_W + 1)'(prev_q.right);
  assign prod_l = diff_l * f_s;
  assign prod_r = diff_r * f_s;

  assign num_l = (PRW'($signed(p1_prev_q.left)) <<< FRAC_BITS) + p1_prod_l_q;
  assign num_r = (PRW'($signed(p1_prev_q.right)) <<< FRAC_BITS) + p1_prod_r_q;

  always_comb begin
    res_push_o     = p1_valid_q;
    res_o.last     = p1_last_q;
    res_o.pair.left  = p1_tail_q ? p1_cur_q.left  : scale_down(num_l);
    res_o.pair.right = p1_tail_q ? p1_cur_q.right : scale_down(num_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= issue;
      if (load) begin
        active_q <= 1'b1;
      end else if (issue && done) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q    <= cmd_i.mode;
      tail_en_q <= cmd_i.tail_en;
      ph_q      <= cmd_phase_i;
      step_q    <= cmd_step_i;
      prev_q    <= cmd_i.prev;
      cur_q     <= cmd_i.cur;
    end else if (issue) begin
      if (reach) begin
        // blended run over; held run continues from the wrapped phase
        mode_q <= MODE_TAIL;
        ph_q   <= ph_wrap;
      end else begin
        ph_q <= ph_next[PW-1:0];
      end
    end
    if (issue) begin
      p1_tail_q   <= (mode_q == MODE_TAIL);
      p1_last_q   <= done;
      p1_prev_q   <= prev_q;
      p1_cur_q    <= cur_q;
      p1_prod_l_q <= prod_l;
      p1_prod_r_q <= prod_r;
    end
  end

endmodule

// File: rtl/stereo_linear_resampler_core.sv
// stereo_linear_resampler_core: top level of the stereo linear resampler.
// Front end, command queue, back end and result queue.
// Depends on slr_pkg, slr_front, slr_fifo, slr_back.
//
//   channel  direction  handshake                   payload
//   -------  ---------  --------------------------  -----------------------------
//   input    in         push / full                 left/right sample, block flags
//   result   out        empty / pop                 left/right out, last_of_run
//   config   in         cfg_valid_i / cfg_ready_o   phase step (Q16)
//
// The front takes one item per cycle while the command queue has room.
// The back loads a command, then issues its results and loads the next
// command only after the last of them; each issued result is registered in
// the scale stage before it is pushed to the queue. A full result queue stalls the
// back only; the front keeps taking items until the command queue fills.
// Reset clears both queues, phase and block state; the step returns to 44814.
module stereo_linear_resampler_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [slr_pkg::STEP_CFG_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  slr_pkg::sample_t                left_sample_i,
  input  slr_pkg::sample_t                right_sample_i,
  input  logic                            block_start_i,
  input  logic                            block_end_i,
  output logic                            empty,
  input  logic                            pop,
  output slr_pkg::sample_t                left_out_o,
  output slr_pkg::sample_t                right_out_o,
  output logic                            last_of_run_o
);

  import slr_pkg::*;

  localparam int unsigned PW    = FRAC_BITS + 1;
  localparam int unsigned CMD_W = $bits(cmd_t) + 2 * PW;
  localparam int unsigned RES_W = $bits(res_t);

  pair_t                         sample;
  logic                          cmd_push, cmd_pop, cmd_empty;
  cmd_t                          cmd_in, cmd_out;
  logic [PW-1:0]                 phase_in, step_in, phase_out, step_out;
  logic [CMD_W-1:0]              cmd_rdata;
  logic                          res_push;
  res_t                          res_in, res_out;
  logic [RES_W-1:0]              res_rdata;
  logic [$clog2(OUT_DEPTH + 1)-1:0] res_count;

  assign sample.left  = left_sample_i;
  assign sample.right = right_sample_i;

  slr_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .cmd_full_i   (full),
    .sample_i     (sample),
    .block_start_i(block_start_i),
    .block_end_i  (block_end_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .cmd_phase_o  (phase_in),
    .cmd_step_o   (step_in)
  );

  slr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i({cmd_in, phase_in, step_in}),
    .pop_i  (cmd_pop),
    .full_o (full),
    .empty_o(cmd_empty),
    .rdata_o(cmd_rdata),
    .count_o()
  );

  assign cmd_out   = cmd_rdata[CMD_W-1 -: $bits(cmd_t)];
  assign phase_out = cmd_rdata[2*PW-1 -: PW];
  assign step_out  = cmd_rdata[PW-1:0];

  slr_back #(
    .FRAC_BITS(FRAC_BITS),
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd_out),
    .cmd_phase_i(phase_out),
    .cmd_step_i (step_out),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  slr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .pop_i  (pop),
    .full_o (),
    .empty_o(empty),
    .rdata_o(res_rdata),
    .count_o(res_count)
  );

  assign res_out       = res_rdata;
  assign left_out_o    = res_out.pair.left;
  assign right_out_o   = res_out.pair.right;
  assign last_of_run_o = res_out.last;

endmodule

// File: sim/slr_resample_checker.sv
// slr_resample_checker: watches the input, result and step channels of the resampler,
// predicts every output pair from the accepted items and compares them in order.
// Depends on slr_pkg.
`timescale 1ns / 1ps

module slr_resample_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [slr_pkg::STEP_CFG_W-1:0] cfg_data_i,
  input  logic                           push_i,
  input  logic                           full_i,
  input  slr_pkg::sample_t               left_sample_i,
  input  slr_pkg::sample_t               right_sample_i,
  input  logic                           block_start_i,
  input  logic                           block_end_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  slr_pkg::sample_t               left_out_i,
  input  slr_pkg::sample_t               right_out_i,
  input  logic                           last_of_run_i,
  output int                             fails_o,
  output int                             pending_o
);

  localparam int unsigned ONE     = 1 << FRAC_BITS;
  localparam int unsigned STEP_LO = 1 << (FRAC_BITS - 2);
  localparam int unsigned STEP_HI = (2 << FRAC_BITS) - 1;
  localparam int          MAX_RUN = 8;

  logic [slr_pkg::STEP_CFG_W-1:0] step_reg;
  slr_pkg::sample_t               hist_left;
  slr_pkg::sample_t               hist_right;
  int unsigned                    pos_acc;
  logic                           in_block;
  slr_pkg::res_t                  expected_pairs[$];

  // weight (1 - f) on the older sample, f on the newer; truncates toward zero
  function automatic slr_pkg::sample_t mix(slr_pkg::sample_t a, slr_pkg::sample_t b,
                                           int unsigned f);
    longint num;
    num = longint'(a) * longint'(ONE - f) + longint'(b) * longint'(f);
    return slr_pkg::sample_t'(num / longint'(ONE));
  endfunction

  function automatic void resample_item(slr_pkg::sample_t l, slr_pkg::sample_t r,
                                        logic blk_start, logic blk_end);
    int unsigned   step;
    slr_pkg::res_t run[$];
    slr_pkg::res_t item;
    step = step_reg;
    if (step < STEP_LO) step = STEP_LO;
    if (step > STEP_HI) step = STEP_HI;

    // no previous sample in this block: behave as a block start
    if (blk_start || !in_block) begin
      pos_acc = 0;
    end else begin
      while (pos_acc < ONE && run.size() < MAX_RUN) begin
        item.pair.left  = mix(hist_left, l, pos_acc);
        item.pair.right = mix(hist_right, r, pos_acc);
        item.last       = 1'b0;
        run.push_back(item);
        pos_acc += step;
      end
      pos_acc = (pos_acc >= ONE) ? pos_acc - ONE : 0;
    end

    // tail of the block holds the final sample
    if (blk_end) begin
      while (pos_acc < ONE && run.size() < MAX_RUN) begin
        item.pair.left  = l;
        item.pair.right = r;
        item.last       = 1'b0;
        run.push_back(item);
        pos_acc += step;
      end
      pos_acc  = 0;
      in_block = 1'b0;
    end else begin
      in_block = 1'b1;
    end

    hist_left  = l;
    hist_right = r;
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) expected_pairs.push_back(run[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    slr_pkg::res_t want;
    if (!rst_ni) begin
      step_reg   = slr_pkg::STEP_RESET;
      hist_left  = '0;
      hist_right = '0;
      pos_acc    = 0;
      in_block   = 1'b0;
      expected_pairs.delete();
      fails_o    = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d last_of_run %0b",
                 left_out_i, right_out_i, last_of_run_i);
          fails_o++;
        end else begin
          want = expected_pairs.pop_front();
          if (left_out_i !== want.pair.left) begin
            $error("left_out: expected %0d, got %0d", want.pair.left, left_out_i);
            fails_o++;
          end
          if (right_out_i !== want.pair.right) begin
            $error("right_out: expected %0d, got %0d", want.pair.right, right_out_i);
            fails_o++;
          end
          if (last_of_run_i !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_i);
            fails_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) step_reg = cfg_data_i;
      if (push_i && !full_i)
        resample_item(left_sample_i, right_sample_i, block_start_i, block_end_i);
    end
    pending_o = expected_pairs.size();
  end

endmodule

// File: sim/tb_stereo_linear_resampler_core.sv
// tb_stereo_linear_resampler_core: drives sample items and step writes into the
// resampler with random gaps and stalls; slr_resample_checker does the comparing.
// Depends on slr_pkg, stereo_linear_resampler_core, slr_resample_checker.
`timescale 1ns / 1ps

module tb_stereo_linear_resampler_core;

  localparam int unsigned FRAC_BITS       = 16;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 55;
  localparam int          SETTLE_CYCLES   = 32;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          HOLD_PHASE      = 3;
  localparam int          STEADY_IN_PHASE = 2;
  localparam int          STEADY_OUT_PHASE = 5;
  localparam int          QUIET_LIMIT     = 2000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [slr_pkg::STEP_CFG_W-1:0] cfg_data_i;
  logic                           push;
  logic                           full;
  slr_pkg::sample_t               left_sample_i;
  slr_pkg::sample_t               right_sample_i;
  logic                           block_start_i;
  logic                           block_end_i;
  logic                           empty;
  logic                           pop;
  slr_pkg::sample_t               left_out_o;
  slr_pkg::sample_t               right_out_o;
  logic                           last_of_run_o;

  int fails;
  int pending;
  int phase_no;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  stereo_linear_resampler_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .push(push),
    .full(full),
    .left_sample_i(left_sample_i),
    .right_sample_i(right_sample_i),
    .block_start_i(block_start_i),
    .block_end_i(block_end_i),
    .empty(empty),
    .pop(pop),
    .left_out_o(left_out_o),
    .right_out_o(right_out_o),
    .last_of_run_o(last_of_run_o)
  );

  slr_resample_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .push_i(push),
    .full_i(full),
    .left_sample_i(left_sample_i),
    .right_sample_i(right_sample_i),
    .block_start_i(block_start_i),
    .block_end_i(block_end_i),
    .empty_i(empty),
    .pop_i(pop),
    .left_out_i(left_out_o),
    .right_out_i(right_out_o),
    .last_of_run_i(last_of_run_o),
    .fails_o(fails),
    .pending_o(pending)
  );

  // hangs show up as a long run of cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    pop       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!held && phase_no == HOLD_PHASE) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        pop       <= 1'b0;
      end else begin
        pop <= (phase_no == STEADY_OUT_PHASE) || ($urandom_range(99) >= 30);
      end
    end
  end

  function automatic slr_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return slr_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input slr_pkg::sample_t l, input slr_pkg::sample_t r,
                           input logic blk_start, input logic blk_end);
    @(negedge clk_i);
    while (phase_no != STEADY_IN_PHASE && $urandom_range(99) < 30) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    block_start_i  <= blk_start;
    block_end_i    <= blk_end;
    do @(posedge clk_i); while (full);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // wait for every predicted pair, then for items still inside that yield none
  task automatic drain();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_step(input logic [slr_pkg::STEP_CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly whole blocks with random content, some items with random flags
  task automatic run_blocks(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(10, 1);
        for (int k = 0; k < len; k++)
          send_item(pick_sample(), pick_sample(), k == 0, k == len - 1);
        sent += len;
      end else begin
        send_item(pick_sample(), pick_sample(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [slr_pkg::STEP_CFG_W-1:0] steps[NUM_PHASES];
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    push           = 1'b0;
    left_sample_i  = '0;
    right_sample_i = '0;
    block_start_i  = 1'b0;
    block_end_i    = 1'b0;
    phase_no       = -1;
    steps[0] = 17'd16384;   // four outputs per input
    steps[1] = 17'h1ffff;   // just under two inputs per output
    steps[2] = 17'd0;       // clamps up to the minimum
    steps[3] = slr_pkg::STEP_RESET;
    steps[4] = 17'd65536;   // exactly one
    steps[5] = 17'd16383;
    steps[6] = 17'($urandom_range(131071, 16384));
    steps[7] = 17'($urandom_range(131071, 0));

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset step: no start after reset, full-scale swings, start mid-block,
    // start and end on one item, item after an end without a start
    send_item(16'sd100, -16'sd100, 1'b0, 1'b0);
    send_item(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    send_item(16'shffff, 16'sh0000, 1'b0, 1'b0);
    send_item(16'sh0000, 16'shffff, 1'b0, 1'b1);
    send_item(16'sd1234, -16'sd1234, 1'b0, 1'b0);
    send_item(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
    send_item(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_item(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh5555, 16'shaaaa, 1'b1, 1'b0);
    send_item(16'shaaaa, 16'sh5555, 1'b0, 1'b0);
    send_item(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    send_item(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    send_item(-16'sd5, 16'sd7, 1'b0, 1'b1);
    idle_input();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_step(steps[p]);
      phase_no = p;
      run_blocks(ITEMS_PER_PHASE);
      idle_input();
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
